@@ src/dlsm_pkg.sv @@
`default_nettype none
package dlsm_pkg;

  localparam int unsigned WORD_W = 64;

  localparam logic [7:0] OPC_LIT0   = 8'h30;
  localparam logic [7:0] OPC_LIT31  = 8'h4f;
  localparam logic [7:0] OPC_REG0   = 8'h50;
  localparam logic [7:0] OPC_REG31  = 8'h6f;
  localparam logic [7:0] OPC_BREG0  = 8'h70;
  localparam logic [7:0] OPC_BREG31 = 8'h8f;
  localparam logic [7:0] OPC_DUP    = 8'h12;
  localparam logic [7:0] OPC_OVER   = 8'h14;
  localparam logic [7:0] OPC_PICK   = 8'h15;
  localparam logic [7:0] OPC_SWAP   = 8'h16;
  localparam logic [7:0] OPC_ROT    = 8'h17;
  localparam logic [7:0] OPC_ABS    = 8'h19;
  localparam logic [7:0] OPC_AND    = 8'h1a;
  localparam logic [7:0] OPC_DIV    = 8'h1b;
  localparam logic [7:0] OPC_MINUS  = 8'h1c;
  localparam logic [7:0] OPC_MOD    = 8'h1d;
  localparam logic [7:0] OPC_MUL    = 8'h1e;
  localparam logic [7:0] OPC_NEG    = 8'h1f;
  localparam logic [7:0] OPC_NOT    = 8'h20;
  localparam logic [7:0] OPC_OR     = 8'h21;
  localparam logic [7:0] OPC_PLUS   = 8'h22;
  localparam logic [7:0] OPC_SHL    = 8'h24;
  localparam logic [7:0] OPC_SHR    = 8'h25;
  localparam logic [7:0] OPC_XOR    = 8'h27;
  localparam logic [7:0] OPC_FBREG  = 8'h91;
  localparam logic [7:0] OPC_CFA    = 8'h9c;

  localparam logic [WORD_W-1:0] PTR_BYTES = 64'd8;

  typedef struct packed {
    logic inv;
    logic is_reg;
  } flags_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    flags_t            flags;
  } entry_t;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_MOD
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [1:0] {
    AU_IDLE,
    AU_RUN,
    AU_FIX
  } alu_state_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_READ_CAP,
    ST_PEEK_CAP,
    ST_EXEC,
    ST_ALU_WAIT,
    ST_PUSH,
    ST_TOP,
    ST_TOP_CAP,
    ST_WALK,
    ST_WALK_CAP,
    ST_OUT
  } seq_state_t;

  typedef enum logic [2:0] {
    K_CONST,
    K_DUP,
    K_PEEK,
    K_SWAP,
    K_ROT,
    K_UNARY,
    K_BINARY
  } kind_t;

endpackage
`default_nettype wire

@@ src/dwarf_location_stack_machine.sv @@
`default_nettype none
// Channel   Handshake            Beat contents
// input     in_valid / in_stall  opcode, operand, register_value, last
// output    out_valid / out_stall value, is_register, invalid, depth, done_res, fault
// config    APB, 64-bit data     frame_base at 0x0, canonical_frame_address at 0x8
//
// An operation reads its pops from the one-write, one-read-port stack memory and, for
// an in-range pick or over, the picked entry; mul, div and mod (nonzero divisor) run in
// the bit-serial shift/add unit. A last beat walks down past register entries at the top.
// in_stall is high from accept until the result is loaded into the output register,
// which then waits for out_stall to drop.
// rst clears the sequencer, depth, the sticky fault and both config registers.
module dwarf_location_stack_machine #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         opcode,
  input  logic signed [63:0] operand,
  input  logic [63:0]        register_value,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        value,
  output logic               is_register,
  output logic               invalid,
  output logic [4:0]         depth,
  output logic               done_res,
  output logic               fault,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import dlsm_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

  seq_state_t        state;
  seq_state_t        state_next;
  logic [63:0]       frame_base;
  logic [63:0]       cfa;
  logic [7:0]        op_q;
  logic [63:0]       operand_q;
  logic [63:0]       regv_q;
  logic              last_q;
  kind_t             kind;
  logic [1:0]        npop;
  logic [1:0]        k;
  logic [1:0]        npush;
  logic [1:0]        j;
  logic [DW-1:0]     dep;
  entry_t            slot [3];
  entry_t            push [3];
  entry_t            res;
  logic              fault_seen;

  logic              accept;
  logic              out_load;
  logic              peek_ok;
  logic [AW-1:0]     peek_addr;
  logic [AW-1:0]     top_addr;
  logic              use_alu;
  alu_op_t           alu_op;
  logic              div_zero;
  entry_t            const_ent;
  logic [63:0]       unary_v;
  logic [63:0]       binary_v;
  kind_t             dec_kind;
  logic [1:0]        dec_npop;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  entry_t            mem_wdata;
  logic [AW-1:0]     mem_raddr;
  entry_t            mem_rdata;
  alu_req_t          alu_req;
  logic              alu_done;
  logic [63:0]       alu_result;

  dlsm_stack #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dlsm_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .a      (slot[1].value),
    .b      (slot[0].value),
    .done   (alu_done),
    .result (alu_result)
  );

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = paddr[3] ? cfa : frame_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base <= '0;
      cfa        <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[3]) begin
        cfa <= pwdata;
      end else begin
        frame_base <= pwdata;
      end
    end
  end

  // Decode of the incoming atom.
  always_comb begin
    dec_kind = K_CONST;
    dec_npop = 2'd0;
    case (opcode)
      OPC_DUP: begin
        dec_kind = K_DUP;
        dec_npop = 2'd1;
      end
      OPC_PICK, OPC_OVER: dec_kind = K_PEEK;
      OPC_SWAP: begin
        dec_kind = K_SWAP;
        dec_npop = 2'd2;
      end
      OPC_ROT: begin
        dec_kind = K_ROT;
        dec_npop = 2'd3;
      end
      OPC_ABS, OPC_NEG, OPC_NOT: begin
        dec_kind = K_UNARY;
        dec_npop = 2'd1;
      end
      OPC_AND, OPC_OR, OPC_XOR, OPC_PLUS, OPC_MINUS, OPC_MUL, OPC_SHL, OPC_SHR,
      OPC_DIV, OPC_MOD: begin
        dec_kind = K_BINARY;
        dec_npop = 2'd2;
      end
      default: ;
    endcase
  end

  assign accept   = in_valid && !in_stall;
  assign out_load = (state == ST_OUT) && (!out_valid || !out_stall);
  assign top_addr = AW'(dep - DW'(1));

  always_comb begin
    if (op_q == OPC_PICK) begin
      peek_ok   = operand_q < 64'(dep);
      peek_addr = AW'(dep - DW'(1) - operand_q[DW-1:0]);
    end else begin
      peek_ok   = dep >= DW'(2);
      peek_addr = AW'(dep - DW'(2));
    end
  end

  // Results that do not need the shared unit.
  always_comb begin
    const_ent = '0;
    if (op_q inside {[OPC_LIT0:OPC_LIT31]}) begin
      const_ent.value = 64'(op_q - OPC_LIT0);
    end else if (op_q inside {[OPC_REG0:OPC_REG31]}) begin
      const_ent.value        = regv_q;
      const_ent.flags.is_reg = 1'b1;
    end else if (op_q inside {[OPC_BREG0:OPC_BREG31]}) begin
      const_ent.value        = regv_q + operand_q;
      const_ent.flags.is_reg = 1'b1;
    end else if (op_q == OPC_CFA) begin
      const_ent.value = cfa + PTR_BYTES;
    end else if (op_q == OPC_FBREG) begin
      const_ent.value = frame_base + operand_q;
    end else begin
      const_ent.flags.inv = 1'b1;
    end
  end

  always_comb begin
    case (op_q)
      OPC_ABS: unary_v = slot[0].value[63] ? (64'd0 - slot[0].value) : slot[0].value;
      OPC_NEG: unary_v = 64'd0 - slot[0].value;
      default: unary_v = (slot[0].value == 64'd0) ? 64'd1 : 64'd0;
    endcase
  end

  // For binary atoms slot 0 holds the top (b) and slot 1 the one below (a).
  always_comb begin
    case (op_q)
      OPC_AND:   binary_v = slot[1].value & slot[0].value;
      OPC_OR:    binary_v = slot[1].value | slot[0].value;
      OPC_XOR:   binary_v = slot[1].value ^ slot[0].value;
      OPC_PLUS:  binary_v = slot[1].value + slot[0].value;
      OPC_MINUS: binary_v = slot[1].value - slot[0].value;
      OPC_SHL:   binary_v = (slot[0].value[63:6] == '0) ?
                            (slot[1].value << slot[0].value[5:0]) : 64'd0;
      OPC_SHR:   binary_v = (slot[0].value[63:6] == '0) ?
                            (slot[1].value >> slot[0].value[5:0]) : 64'd0;
      default:   binary_v = 64'd0;
    endcase
  end

  always_comb begin
    use_alu = (kind == K_BINARY) &&
              (op_q == OPC_MUL || op_q == OPC_DIV || op_q == OPC_MOD);
    case (op_q)
      OPC_DIV: alu_op = ALU_DIV;
      OPC_MOD: alu_op = ALU_MOD;
      default: alu_op = ALU_MUL;
    endcase
    div_zero = (op_q == OPC_DIV || op_q == OPC_MOD) && (slot[0].value == 64'd0);
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_READ;
      ST_READ: begin
        if (k != npop) begin
          if (dep != '0) state_next = ST_READ_CAP;
        end else if (kind == K_PEEK && peek_ok) begin
          state_next = ST_PEEK_CAP;
        end else begin
          state_next = ST_EXEC;
        end
      end
      ST_READ_CAP: state_next = ST_READ;
      ST_PEEK_CAP: state_next = ST_EXEC;
      ST_EXEC:     state_next = (use_alu && !div_zero) ? ST_ALU_WAIT : ST_PUSH;
      ST_ALU_WAIT: if (alu_done) state_next = ST_PUSH;
      ST_PUSH:     if (j == npush) state_next = last_q ? ST_WALK : ST_TOP;
      ST_TOP:      state_next = (dep == '0) ? ST_OUT : ST_TOP_CAP;
      ST_TOP_CAP:  state_next = ST_OUT;
      ST_WALK:     state_next = (dep == '0) ? ST_OUT : ST_WALK_CAP;
      ST_WALK_CAP: begin
        if (!(mem_rdata.flags.is_reg && !mem_rdata.flags.inv && dep > DW'(1))) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT:      if (out_load) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall      = 1'b1;
    mem_we        = 1'b0;
    mem_waddr     = dep[AW-1:0];
    mem_wdata     = push[j];
    mem_raddr     = top_addr;
    alu_req.start = 1'b0;
    alu_req.op    = alu_op;
    case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_READ: if (k == npop) mem_raddr = peek_addr;
      ST_EXEC: alu_req.start = use_alu && !div_zero;
      ST_PUSH: mem_we = (j != npush) && (dep < DW'(STACK_DEPTH));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      dep        <= '0;
      fault_seen <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_READ: if (k != npop && dep != '0) dep <= dep - DW'(1);
        ST_EXEC: if (use_alu && div_zero) fault_seen <= 1'b1;
        ST_PUSH: begin
          if (j != npush) begin
            if (dep < DW'(STACK_DEPTH)) begin
              dep <= dep + DW'(1);
            end else begin
              fault_seen <= 1'b1;
            end
          end
        end
        ST_WALK: if (dep != '0) dep <= dep - DW'(1);
        ST_WALK_CAP: begin
          // The walk keeps going past register values but never walks past the bottom entry.
          if (mem_rdata.flags.is_reg && !mem_rdata.flags.inv && dep > DW'(1)) begin
            dep <= dep - DW'(1);
          end else begin
            dep <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          op_q      <= opcode;
          operand_q <= operand;
          regv_q    <= register_value;
          last_q    <= last;
          kind      <= dec_kind;
          npop      <= dec_npop;
          k         <= 2'd0;
        end
      end
      ST_READ: begin
        if (k != npop) begin
          if (dep == '0) begin
            slot[k] <= '0;
            k       <= k + 2'd1;
          end
        end else if (kind == K_PEEK && !peek_ok) begin
          slot[0] <= '0;
        end
      end
      ST_READ_CAP: begin
        slot[k] <= mem_rdata;
        k       <= k + 2'd1;
      end
      ST_PEEK_CAP: slot[0] <= mem_rdata;
      ST_EXEC: begin
        j <= 2'd0;
        npush <= 2'd1;
        case (kind)
          K_CONST: push[0] <= const_ent;
          K_DUP: begin
            push[0] <= slot[0];
            push[1] <= slot[0];
            npush   <= 2'd2;
          end
          K_PEEK:  push[0] <= '{value: slot[0].value, flags: '0};
          K_SWAP: begin
            push[0] <= slot[0];
            push[1] <= slot[1];
            npush   <= 2'd2;
          end
          K_ROT: begin
            push[0] <= slot[0];
            push[1] <= slot[2];
            push[2] <= slot[1];
            npush   <= 2'd3;
          end
          K_UNARY: push[0] <= '{value: unary_v, flags: '0};
          default: push[0] <= '{value: binary_v, flags: '0};
        endcase
      end
      ST_ALU_WAIT: if (alu_done) push[0] <= '{value: alu_result, flags: '0};
      ST_PUSH:     if (j != npush) j <= j + 2'd1;
      ST_TOP:      if (dep == '0) res <= '0;
      ST_TOP_CAP:  res <= mem_rdata;
      ST_WALK:     if (dep == '0) res <= '0;
      ST_WALK_CAP: res <= mem_rdata;
      default: ;
    endcase
    if (out_load) begin
      value       <= res.value;
      is_register <= res.flags.is_reg;
      invalid     <= res.flags.inv;
      depth       <= 5'(dep);
      done_res    <= last_q;
      fault       <= fault_seen;
    end
  end

endmodule
`default_nettype wire

@@ src/dlsm_stack.sv @@
`default_nettype none
module dlsm_stack #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  dlsm_pkg::entry_t  wdata,
  input  logic [AW-1:0]     raddr,
  output dlsm_pkg::entry_t  rdata
);
  import dlsm_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/dlsm_alu.sv @@
`default_nettype none
module dlsm_alu (
  input  logic                        clk,
  input  logic                        rst,
  input  dlsm_pkg::alu_req_t          req,
  input  logic [dlsm_pkg::WORD_W-1:0] a,
  input  logic [dlsm_pkg::WORD_W-1:0] b,
  output logic                        done,
  output logic [dlsm_pkg::WORD_W-1:0] result
);
  import dlsm_pkg::*;

  alu_state_t        state;
  alu_state_t        state_next;
  alu_op_t           op_q;
  logic [5:0]        cnt;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] x;
  logic [WORD_W-1:0] y;
  logic              neg_q;
  logic              load;
  logic              step;
  logic              finish;
  logic [WORD_W:0]   add_a;
  logic [WORD_W:0]   add_b;
  logic              cin;
  logic [WORD_W+1:0] sum;

  always_comb begin
    state_next = state;
    case (state)
      AU_IDLE: if (req.start) state_next = AU_RUN;
      AU_RUN:  if (cnt == 6'd63) state_next = AU_FIX;
      AU_FIX:  state_next = AU_IDLE;
      default: state_next = AU_IDLE;
    endcase
  end

  always_comb begin
    load   = 1'b0;
    step   = 1'b0;
    finish = 1'b0;
    case (state)
      AU_IDLE: load = req.start;
      AU_RUN:  step = 1'b1;
      AU_FIX:  finish = 1'b1;
      default: ;
    endcase
  end

  // One adder serves both loops: accumulate for multiply, trial subtract for divide and modulo.
  always_comb begin
    if (op_q == ALU_MUL) begin
      add_a = {1'b0, acc};
      add_b = {1'b0, x};
      cin   = 1'b0;
    end else begin
      add_a = {acc, x[WORD_W-1]};
      add_b = {1'b1, ~y};
      cin   = 1'b1;
    end
    sum = (WORD_W+2)'(add_a) + (WORD_W+2)'(add_b) + (WORD_W+2)'(cin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AU_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_q <= req.op;
      cnt  <= '0;
      acc  <= '0;
      case (req.op)
        ALU_DIV: begin
          x     <= a[WORD_W-1] ? (WORD_W'(0) - a) : a;
          y     <= b[WORD_W-1] ? (WORD_W'(0) - b) : b;
          neg_q <= a[WORD_W-1] ^ b[WORD_W-1];
        end
        default: begin
          x     <= a;
          y     <= b;
          neg_q <= 1'b0;
        end
      endcase
    end
    if (step) begin
      cnt <= cnt + 6'd1;
      if (op_q == ALU_MUL) begin
        if (y[0]) begin
          acc <= sum[WORD_W-1:0];
        end
        x <= {x[WORD_W-2:0], 1'b0};
        y <= {1'b0, y[WORD_W-1:1]};
      end else if (sum[WORD_W+1]) begin
        acc <= sum[WORD_W-1:0];
        x   <= {x[WORD_W-2:0], 1'b1};
      end else begin
        acc <= {acc[WORD_W-2:0], x[WORD_W-1]};
        x   <= {x[WORD_W-2:0], 1'b0};
      end
    end
    if (finish) begin
      case (op_q)
        ALU_DIV: result <= neg_q ? (WORD_W'(0) - x) : x;
        default: result <= acc;
      endcase
    end
  end

endmodule
`default_nettype wire
